@@ src/pcog_pkg.sv @@
// ----------------------------------------------------------------------------
// pcog_pkg: shared types and constants of the point cloud occupancy grid
// Holds the request and result payloads, the queue entry between the front
// and back parts, the register map and the mark codes.
// ----------------------------------------------------------------------------
package pcog_pkg;

  // Default geometry: range offset in whole units, cell size, grid side.
  localparam int RANGE_DEF     = 300;
  localparam int CELL_SIZE_DEF = 5;
  localparam int GRID_SIDE_DEF = 120;

  // Widest cell address the supported grid sides can need (1024 x 1024).
  localparam int ADDR_MAX_W = 20;

  // Coordinate widths: whole-unit sum after the range offset, and bin index.
  localparam int SUM_W = 18;
  localparam int Q_W   = 16;

  localparam int COORD_W = 24;
  localparam int COUNT_W = 8;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

  // Register map.
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 24;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT_THR = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_OCC_THR    = 8'd1;
  localparam logic signed [COORD_W-1:0] HEIGHT_THR_RESET = 24'sd768;
  localparam logic [COUNT_W-1:0]        OCC_THR_RESET    = 8'd10;

  // Opcodes.
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Cell marks.
  localparam logic [1:0] MARK_EMPTY    = 2'd0;
  localparam logic [1:0] MARK_OCCUPIED = 2'd1;
  localparam logic [1:0] MARK_CENTER   = 2'd2;

  // Queue depths.
  localparam int CMD_DEPTH = 4;
  localparam int RES_DEPTH = 4;

  typedef struct packed {
    logic                      opcode;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic [6:0]                cell_row;
    logic [6:0]                cell_col;
  } item_t;

  typedef struct packed {
    logic [1:0]         cell_mark;
    logic [COUNT_W-1:0] cell_count;
  } result_t;

  // One classified request on its way from the front part to the back part.
  typedef struct packed {
    logic                  is_read;
    logic                  in_range;
    logic                  center;
    logic [ADDR_MAX_W-1:0] addr;
  } cmd_t;

endpackage

@@ src/pcog_fifo.sv @@
// ----------------------------------------------------------------------------
// pcog_fifo: small register queue
// Holds a few entries of any packed type; the head entry is shown while the
// queue is not empty and the fill level is available to the user.
// ----------------------------------------------------------------------------
module pcog_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  T                           din,
  output logic                       full,
  input  logic                       pop,
  output T                           dout,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  T                 store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ src/pcog_front.sv @@
// ----------------------------------------------------------------------------
// pcog_front: request intake and classification
// Three-stage pipeline that turns an add request into a cell address (or
// drops it) and passes read requests through, feeding the command queue.
// ----------------------------------------------------------------------------
module pcog_front #(
  parameter int RANGE     = pcog_pkg::RANGE_DEF,
  parameter int CELL_SIZE = pcog_pkg::CELL_SIZE_DEF,
  parameter int GRID_SIDE = pcog_pkg::GRID_SIDE_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              hold,
  input  logic                              push,
  output logic                              full,
  input  pcog_pkg::item_t                   item,
  input  logic signed [pcog_pkg::COORD_W-1:0] height_thr,
  output logic                              cmd_push,
  output pcog_pkg::cmd_t                    cmd,
  input  logic                              cmd_full
);

  import pcog_pkg::*;

  localparam int DIV_SHIFT = Q_W + 1;
  localparam int RECIP     = (1 << DIV_SHIFT) / CELL_SIZE;
  localparam int PROD_W    = Q_W + DIV_SHIFT + 2;
  localparam int REM_W     = Q_W + $clog2(CELL_SIZE + 1);
  localparam int CENTER    = GRID_SIDE / 2;
  localparam int IDX_W     = $clog2(GRID_SIDE);
  localparam int ADDR_W    = $clog2(GRID_SIDE * GRID_SIDE);

  // Whole units truncated toward zero, plus the range offset.
  function automatic logic [SUM_W-1:0] offset_sum(input logic [COORD_W-1:0] q);
    logic [SUM_W-1:0] whole;
    logic [SUM_W-1:0] adj;
    whole = {{(SUM_W - Q_W){q[COORD_W-1]}}, q[COORD_W-1:8]};
    adj   = SUM_W'(q[COORD_W-1] & (|q[7:0]));
    return whole + SUM_W'(RANGE) + adj;
  endfunction

  logic             advance;
  logic             accept;

  logic             s1_valid;
  logic             s1_read;
  logic             s1_keep;
  logic [SUM_W-1:0] s1_sum_x;
  logic [SUM_W-1:0] s1_sum_z;

  logic             s2_valid;
  logic             s2_read;
  logic             s2_keep;
  logic [Q_W-1:0]   s2_sum_x;
  logic [Q_W-1:0]   s2_sum_z;
  logic [Q_W-1:0]   s2_qe_x;
  logic [Q_W-1:0]   s2_qe_z;

  logic             s3_valid;
  logic             s3_read;
  logic             s3_keep;
  logic [Q_W-1:0]   s3_q_x;
  logic [Q_W-1:0]   s3_q_z;

  logic [PROD_W-1:0] prod_x;
  logic [PROD_W-1:0] prod_z;
  logic [REM_W-1:0]  rem_x;
  logic [REM_W-1:0]  rem_z;
  logic [Q_W-1:0]    q_x;
  logic [Q_W-1:0]    q_z;
  logic              in_range;
  logic [ADDR_W-1:0] addr;

  // The whole pipeline holds while its last stage waits on a full queue.
  assign advance = !(s3_valid && cmd_full);
  assign full    = !advance || hold;
  assign accept  = push && !full;

  // Stage 2 reciprocal multiply: an estimate of sum / CELL_SIZE that is low
  // by at most one.
  assign prod_x = PROD_W'(s1_sum_x[Q_W-1:0]) * PROD_W'(RECIP);
  assign prod_z = PROD_W'(s1_sum_z[Q_W-1:0]) * PROD_W'(RECIP);

  // Stage 3 correction of the estimate by one compare.
  assign rem_x = REM_W'(s2_sum_x) - REM_W'(s2_qe_x) * REM_W'(CELL_SIZE);
  assign rem_z = REM_W'(s2_sum_z) - REM_W'(s2_qe_z) * REM_W'(CELL_SIZE);
  assign q_x   = (!s2_read && (rem_x >= REM_W'(CELL_SIZE))) ? s2_qe_x + 1'b1 : s2_qe_x;
  assign q_z   = (!s2_read && (rem_z >= REM_W'(CELL_SIZE))) ? s2_qe_z + 1'b1 : s2_qe_z;

  // Output side: bounds check and linear cell address.
  assign in_range = (32'(s3_q_x) < GRID_SIDE) && (32'(s3_q_z) < GRID_SIDE);
  assign addr     = ADDR_W'(s3_q_x[IDX_W-1:0]) * ADDR_W'(GRID_SIDE)
                  + ADDR_W'(s3_q_z[IDX_W-1:0]);

  always_comb begin
    cmd.is_read  = s3_read;
    cmd.in_range = in_range;
    cmd.center   = (32'(s3_q_x) == CENTER) && (32'(s3_q_z) == CENTER);
    cmd.addr     = in_range ? ADDR_MAX_W'(addr) : '0;
    cmd_push     = s3_valid && !cmd_full && (s3_read || (s3_keep && in_range));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_read <= (item.opcode == OP_READ);
      if (item.opcode == OP_READ) begin
        s1_keep  <= 1'b1;
        s1_sum_x <= SUM_W'(item.cell_row);
        s1_sum_z <= SUM_W'(item.cell_col);
      end else begin
        s1_keep  <= (item.point_y > height_thr);
        s1_sum_x <= offset_sum(item.point_x);
        s1_sum_z <= offset_sum(item.point_z);
      end

      s2_read  <= s1_read;
      s2_keep  <= s1_keep && (s1_read || (!s1_sum_x[SUM_W-1] && !s1_sum_z[SUM_W-1]));
      s2_sum_x <= s1_sum_x[Q_W-1:0];
      s2_sum_z <= s1_sum_z[Q_W-1:0];
      s2_qe_x  <= s1_read ? s1_sum_x[Q_W-1:0] : prod_x[DIV_SHIFT+Q_W-1:DIV_SHIFT];
      s2_qe_z  <= s1_read ? s1_sum_z[Q_W-1:0] : prod_z[DIV_SHIFT+Q_W-1:DIV_SHIFT];

      s3_read <= s2_read;
      s3_keep <= s2_keep;
      s3_q_x  <= q_x;
      s3_q_z  <= q_z;
    end
  end

endmodule

@@ src/pcog_back.sv @@
// ----------------------------------------------------------------------------
// pcog_back: counter memory and result path
// Clears the counter memory after reset, then runs each queued request as a
// read-modify-write or a read, and queues the results of reads.
// ----------------------------------------------------------------------------
module pcog_back #(
  parameter int GRID_SIDE = pcog_pkg::GRID_SIDE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  output logic                        clearing,
  input  logic                        cmd_empty,
  output logic                        cmd_pop,
  input  pcog_pkg::cmd_t              cmd,
  input  logic [pcog_pkg::COUNT_W-1:0] occ_thr,
  output logic                        empty,
  input  logic                        pop,
  output pcog_pkg::result_t           result
);

  import pcog_pkg::*;

  localparam int CELLS     = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  logic [COUNT_W-1:0]   mem [CELLS];
  logic [COUNT_W-1:0]   mem_rd;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_wa;
  logic [COUNT_W-1:0]   mem_wd;

  logic [ADDR_W-1:0]    clr_addr;
  logic                 exe_valid;
  cmd_t                 exe_cmd;
  logic                 fwd;
  logic [COUNT_W-1:0]   last_wd;
  logic [COUNT_W-1:0]   cur;
  logic [COUNT_W-1:0]   incr;
  logic [RES_CNT_W-1:0] res_count;
  logic                 res_push;
  result_t              res_in;

  // A request is taken only while the result queue keeps room for it and
  // for the one still in flight.
  assign cmd_pop = !clearing && !cmd_empty && (res_count <= RES_CNT_W'(RES_DEPTH - 2));

  // The write of the previous request lands after this read was issued.
  assign cur  = fwd ? last_wd : mem_rd;
  assign incr = (cur == COUNT_MAX) ? cur : cur + 1'b1;

  assign mem_we = clearing || (exe_valid && !exe_cmd.is_read);
  assign mem_wa = clearing ? clr_addr : exe_cmd.addr[ADDR_W-1:0];
  assign mem_wd = clearing ? '0 : incr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd_pop) begin
      mem_rd <= mem[cmd.addr[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_addr  <= '0;
      exe_valid <= 1'b0;
      fwd       <= 1'b0;
    end else begin
      if (clearing) begin
        if (clr_addr == ADDR_W'(CELLS - 1)) begin
          clearing <= 1'b0;
        end
        clr_addr <= clr_addr + 1'b1;
      end
      exe_valid <= cmd_pop;
      fwd       <= cmd_pop && exe_valid && !exe_cmd.is_read && (exe_cmd.addr == cmd.addr);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      exe_cmd <= cmd;
    end
    if (mem_we) begin
      last_wd <= mem_wd;
    end
  end

  always_comb begin
    res_push          = exe_valid && exe_cmd.is_read;
    res_in.cell_count = exe_cmd.in_range ? cur : '0;
    priority if (res_in.cell_count > occ_thr) begin
      res_in.cell_mark = MARK_OCCUPIED;
    end else if (exe_cmd.in_range && exe_cmd.center) begin
      res_in.cell_mark = MARK_CENTER;
    end else begin
      res_in.cell_mark = MARK_EMPTY;
    end
  end

  pcog_fifo #(
    .T     (result_t),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (),
    .pop   (pop),
    .dout  (result),
    .empty (empty),
    .count (res_count)
  );

endmodule

@@ src/point_cloud_occupancy_grid.sv @@
// ----------------------------------------------------------------------------
// point_cloud_occupancy_grid: 2D histogram of high points
// Counts points above a height threshold in a square grid of saturating
// 8-bit cells and answers read requests with a cell's count and mark.
// ----------------------------------------------------------------------------
//
//   Channel  | Handshake               | Payload
//   ---------+-------------------------+------------------------------------
//   request  | push / full             | item   (opcode, point, cell)
//   result   | pop / empty             | result (cell_mark, cell_count)
//   config   | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One request is taken per cycle when nothing stalls. A request passes the
// front pipeline (offset, reciprocal multiply, correction and addressing),
// waits in the command queue, and then passes the back part: the registered
// memory read and then the write of the incremented count, with a bypass for
// back-to-back updates of one cell. After reset the back part clears all
// GRID_SIDE * GRID_SIDE counters, one per cycle; full stays high meanwhile.
// When result pops stall, the result queue fills, then the command queue,
// then the front pipeline, which raises full. Configuration writes are taken
// in every cycle.
// ----------------------------------------------------------------------------
module point_cloud_occupancy_grid #(
  parameter int RANGE     = pcog_pkg::RANGE_DEF,
  parameter int CELL_SIZE = pcog_pkg::CELL_SIZE_DEF,
  parameter int GRID_SIDE = pcog_pkg::GRID_SIDE_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  pcog_pkg::item_t                     item,
  output logic                                empty,
  input  logic                                pop,
  output pcog_pkg::result_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pcog_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [pcog_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import pcog_pkg::*;

  // Configuration registers.
  logic signed [COORD_W-1:0] height_thr;
  logic [COUNT_W-1:0]        occ_thr;

  // Front to queue to back.
  logic front_full;
  logic cmd_push;
  cmd_t cmd_in;
  logic cmd_full;
  logic cmd_pop;
  cmd_t cmd_out;
  logic cmd_empty;
  logic clearing;

  // The write channel never stalls; writes with an unknown index are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      height_thr <= HEIGHT_THR_RESET;
      occ_thr    <= OCC_THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HEIGHT_THR: height_thr <= cfg_data;
        CFG_OCC_THR:    occ_thr    <= cfg_data[COUNT_W-1:0];
        default:        ;
      endcase
    end
  end

  // No request is taken while the counter memory is being cleared.
  assign full = front_full;

  pcog_front #(
    .RANGE     (RANGE),
    .CELL_SIZE (CELL_SIZE),
    .GRID_SIDE (GRID_SIDE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .hold       (clearing),
    .push       (push),
    .full       (front_full),
    .item       (item),
    .height_thr (height_thr),
    .cmd_push   (cmd_push),
    .cmd        (cmd_in),
    .cmd_full   (cmd_full)
  );

  pcog_fifo #(
    .T     (cmd_t),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty),
    .count ()
  );

  pcog_back #(
    .GRID_SIDE (GRID_SIDE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .clearing  (clearing),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd_out),
    .occ_thr   (occ_thr),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

@@ src/pcog_checker.sv @@
// ----------------------------------------------------------------------------
// pcog_checker: port-level checks of the occupancy grid
// Watches the top level's ports for the reset behavior, result holding and
// the consistency of result fields.
// ----------------------------------------------------------------------------
module pcog_checker (
  input logic              clk,
  input logic              rst,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input pcog_pkg::result_t result
);

  import pcog_pkg::*;

  // The counter memory is being cleared right after reset.
  assert property (@(posedge clk) disable iff (rst) $past(rst) |-> full)
    else $error("request side open right after reset");

  // Reset leaves no result waiting.
  assert property (@(posedge clk) disable iff (rst) $past(rst) |-> empty)
    else $error("result shown right after reset");

  // A waiting result that is not popped stays as it is.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && (result == $past(result))))
    else $error("waiting result changed or vanished");

  // An occupied cell has a count above a threshold of at least zero.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && (result.cell_mark == MARK_OCCUPIED)) |-> (result.cell_count != '0))
    else $error("occupied mark with zero count");

endmodule

bind point_cloud_occupancy_grid pcog_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for the point cloud occupancy grid
// Feeds add-point and read requests through the push/full queue and checks
// every read result against a cycle-free software grid kept in the bench.
// A short directed table covers bin edges, truncation toward zero, the
// height boundary and reads outside the grid. Random traffic follows under
// several threshold settings, with one cell driven into saturation and one
// long result stall that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb;
  import pcog_pkg::*;

  // Coordinate extremes of a signed Q16.8 field.
  localparam int COORD_MAX = 8388607;
  localparam int COORD_MIN = -8388608;

  // A register index that the block does not map; writes to it change nothing.
  localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = 8'hFE;

  localparam int GRID_CELLS  = GRID_SIDE_DEF * GRID_SIDE_DEF;
  localparam int CENTER_BIN  = GRID_SIDE_DEF / 2;

  // Waiting SETTLE_CYCLES after the last read result is back makes sure
  // trailing add-point requests have reached the grid too.
  localparam int SETTLE_CYCLES = 30;

  // Longest stretch without any handshake. The clearing pass after reset
  // alone takes one cycle per cell, so the limit sits well above that.
  localparam int WATCHDOG_LIMIT = 60000;

  // Length of the deliberate result stall that fills the block.
  localparam int LONG_STALL = 300;

  typedef struct packed {
    item_t   req;
    logic    typed;
    result_t typed_res;
  } directed_entry_t;

  logic    clk       = 1'b0;
  logic    rst       = 1'b1;
  logic    push      = 1'b0;
  logic    full;
  item_t   item      = '0;
  logic    empty;
  logic    pop       = 1'b0;
  result_t result;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // Software copy of the grid and of both thresholds.
  bit [COUNT_W-1:0]          grid_model [GRID_CELLS];
  logic signed [COORD_W-1:0] height_thr = HEIGHT_THR_RESET;
  logic [COUNT_W-1:0]        occ_thr    = OCC_THR_RESET;

  // Read results still owed by the block, oldest first.
  result_t expected_reads [$];

  // Cells that the random traffic aims at, so that counts climb past the
  // occupancy threshold. The last slot moves with every new setting.
  int hot_row [6] = '{60, 0, 119, 0, 59, 7};
  int hot_col [6] = '{60, 0, 119, 119, 61, 93};

  bit steady_tail   = 1'b0;   // no idling on either side from here on
  bit stall_results = 1'b0;   // asks the result side for one long stall

  int mismatches   = 0;
  int requests     = 0;
  int reads_sent   = 0;
  int results_seen = 0;
  int cfg_writes   = 0;
  int settings     = 0;

  result_t oldest_read;

  always #5 clk = ~clk;

  point_cloud_occupancy_grid u_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Grid predictor
  // --------------------------------------------------------------------------

  // Whole-unit part (truncated toward zero), shifted by the range offset and
  // divided into a bin. Returns -1 when the coordinate lands off the grid.
  function automatic int grid_bin(logic signed [COORD_W-1:0] q);
    int whole;
    int shifted;
    whole   = int'(q) / 256;
    shifted = whole + RANGE_DEF;
    if (shifted < 0) begin
      return -1;
    end
    if (shifted / CELL_SIZE_DEF >= GRID_SIDE_DEF) begin
      return -1;
    end
    return shifted / CELL_SIZE_DEF;
  endfunction

  // Applies one accepted request to the software grid. A read owes a result:
  // either the one worked out here, or one typed into the directed table.
  function automatic void predict_grid_request(item_t req, logic typed,
                                               result_t typed_res);
    int      row;
    int      col;
    int      addr;
    result_t cell_res;
    requests++;
    if (req.opcode == OP_ADD) begin
      if (signed'(req.point_y) <= height_thr) begin
        return;
      end
      row = grid_bin(req.point_x);
      col = grid_bin(req.point_z);
      if (row < 0 || col < 0) begin
        return;
      end
      addr = row * GRID_SIDE_DEF + col;
      if (grid_model[addr] != COUNT_MAX) begin
        grid_model[addr] = grid_model[addr] + 1'b1;
      end
    end else begin
      row      = req.cell_row;
      col      = req.cell_col;
      cell_res = '{cell_mark: MARK_EMPTY, cell_count: '0};
      if (row < GRID_SIDE_DEF && col < GRID_SIDE_DEF) begin
        cell_res.cell_count = grid_model[row * GRID_SIDE_DEF + col];
        if (cell_res.cell_count > occ_thr) begin
          cell_res.cell_mark = MARK_OCCUPIED;
        end else if (row == CENTER_BIN && col == CENTER_BIN) begin
          cell_res.cell_mark = MARK_CENTER;
        end
      end
      reads_sent++;
      expected_reads.push_back(typed ? typed_res : cell_res);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Request builders
  // --------------------------------------------------------------------------

  // The cell fields of an add are ignored, so they carry noise.
  function automatic item_t add_point(int x, int y, int z);
    item_t req;
    req          = '0;
    req.opcode   = OP_ADD;
    req.point_x  = x[COORD_W-1:0];
    req.point_y  = y[COORD_W-1:0];
    req.point_z  = z[COORD_W-1:0];
    req.cell_row = 7'($urandom);
    req.cell_col = 7'($urandom);
    return req;
  endfunction

  // The point fields of a read are ignored, so they carry noise.
  function automatic item_t read_cell(int row, int col);
    item_t req;
    req          = '0;
    req.opcode   = OP_READ;
    req.point_x  = COORD_W'($urandom);
    req.point_y  = COORD_W'($urandom);
    req.point_z  = COORD_W'($urandom);
    req.cell_row = row[6:0];
    req.cell_col = col[6:0];
    return req;
  endfunction

  // A coordinate that falls into the given bin. The fraction goes away from
  // zero, so a wrong rounding direction moves the point into another bin.
  function automatic int coord_in_bin(int bin);
    int whole;
    int frac;
    whole = bin * CELL_SIZE_DEF + int'($urandom_range(0, CELL_SIZE_DEF - 1)) - RANGE_DEF;
    frac  = int'($urandom_range(0, 255));
    if (whole > 0) begin
      return whole * 256 + frac;
    end else if (whole < 0) begin
      return whole * 256 - frac;
    end
    return $urandom_range(0, 1) ? frac : -frac;
  endfunction

  // Mostly just above the height threshold, sometimes right on it (not
  // counted) and sometimes anywhere at all.
  function automatic int pick_height();
    int level;
    case ($urandom_range(0, 5))
      0: begin
        level = int'($urandom);
        return int'(signed'(level[COORD_W-1:0]));
      end
      1: begin
        return int'(height_thr);
      end
      default: begin
        level = int'(height_thr) + int'($urandom_range(1, 3000));
        return (level > COORD_MAX) ? COORD_MAX : level;
      end
    endcase
  endfunction

  function automatic item_t random_request();
    int           slot;
    logic [95:0]  noise;
    slot  = $urandom_range(0, 5);
    noise = {$urandom, $urandom, $urandom};
    case ($urandom_range(0, 9))
      0: begin
        return noise[$bits(item_t)-1:0];
      end
      1, 2, 3, 4: begin
        return add_point(coord_in_bin(hot_row[slot]), pick_height(),
                         coord_in_bin(hot_col[slot]));
      end
      5: begin
        return add_point(coord_in_bin($urandom_range(0, GRID_SIDE_DEF - 1)), pick_height(),
                         coord_in_bin($urandom_range(0, GRID_SIDE_DEF - 1)));
      end
      9: begin
        return read_cell($urandom_range(0, 127), $urandom_range(0, 127));
      end
      default: begin
        return read_cell(hot_row[slot], hot_col[slot]);
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Offers one request, now and then after a burst of idle cycles, and holds
  // it until the block takes it. Push stays high between back-to-back
  // requests, so it is never lowered and raised within one time step.
  task automatic offer(input item_t req, input logic typed, input result_t typed_res,
                       input bit may_idle);
    int gap;
    gap = 0;
    if (may_idle && !steady_tail && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 19);
    end
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= req;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_grid_request(req, typed, typed_res);
  endtask

  task automatic run_random(input int count);
    repeat (count) offer(random_request(), 1'b0, '0, 1'b1);
  endtask

  // Stops sending until every owed result is back, then lets trailing adds
  // drain out of the pipeline and the command queue.
  task automatic settle();
    push <= 1'b0;
    while (expected_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both thresholds while the block is idle. An extra write to an
  // unmapped index sits between them and must leave everything unchanged.
  task automatic set_thresholds(input logic signed [COORD_W-1:0] height,
                                input logic [COUNT_W-1:0] occ);
    logic [31:0] noise;
    noise = $urandom;
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_HEIGHT_THR;
    cfg_data  <= height;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    height_thr = height;
    cfg_index <= CFG_UNMAPPED;
    cfg_data  <= noise[CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_OCC_THR;
    cfg_data  <= {noise[31:16], occ};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    occ_thr = occ;
    cfg_valid <= 1'b0;
    cfg_writes += 3;
    settings++;
    hot_row[5] = $urandom_range(0, GRID_SIDE_DEF - 1);
    hot_col[5] = $urandom_range(0, GRID_SIDE_DEF - 1);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random pop bursts, one long stall on request, and none at
  // all once the steady tail of the run has begun.
  // --------------------------------------------------------------------------
  initial begin : result_side
    wait (!rst);
    forever begin
      if (stall_results) begin
        pop <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        stall_results = 1'b0;
      end else if (!steady_tail && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Every popped result is compared with the oldest read still owed.
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (expected_reads.size() == 0) begin
        $error("result with no read waiting: cell_mark %0d, cell_count %0d",
               result.cell_mark, result.cell_count);
        mismatches++;
      end else begin
        oldest_read = expected_reads.pop_front();
        results_seen++;
        if (result.cell_mark !== oldest_read.cell_mark) begin
          $error("cell_mark: expected %0d, actual %0d",
                 oldest_read.cell_mark, result.cell_mark);
          mismatches++;
        end
        if (result.cell_count !== oldest_read.cell_count) begin
          $error("cell_count: expected %0d, actual %0d",
                 oldest_read.cell_count, result.cell_count);
          mismatches++;
        end
      end
    end
  end

  // Ends the run if no handshake of any kind happens for too long.
  initial begin : watchdog
    int silent;
    silent = 0;
    while (silent < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
        silent = 0;
      end else begin
        silent++;
      end
    end
    $display("tb failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    directed_entry_t directed [$];

    // Directed table. Reads of a freshly cleared grid, and reads off the
    // grid, have results that are known outright; everything else goes
    // through the predictor.
    directed.push_back('{read_cell(0, 0), 1'b1, '{MARK_EMPTY, 8'd0}});
    directed.push_back('{read_cell(CENTER_BIN, CENTER_BIN), 1'b1, '{MARK_CENTER, 8'd0}});
    directed.push_back('{read_cell(119, 119), 1'b1, '{MARK_EMPTY, 8'd0}});
    directed.push_back('{read_cell(127, 5), 1'b1, '{MARK_EMPTY, 8'd0}});
    directed.push_back('{read_cell(5, 120), 1'b1, '{MARK_EMPTY, 8'd0}});
    // A point at the origin counts like any other point: it lands in the
    // vehicle centre cell, which stays marked as such while not occupied.
    directed.push_back('{add_point(0, COORD_MAX, 0), 1'b0, '0});
    directed.push_back('{read_cell(CENTER_BIN, CENTER_BIN), 1'b0, '0});
    // Height exactly on the threshold is dropped, one step above counts.
    directed.push_back('{add_point(0, 768, 0), 1'b0, '0});
    directed.push_back('{add_point(0, 769, 0), 1'b0, '0});
    // Most negative x: the offset sum stays negative and the point is lost.
    directed.push_back('{add_point(COORD_MIN, COORD_MAX, 0), 1'b0, '0});
    // Just below -300.0 still truncates to -300, which is row zero.
    directed.push_back('{add_point(-76801, 1000, -76800), 1'b0, '0});
    directed.push_back('{add_point(-77056, 1000, 0), 1'b0, '0});
    // Last bin of the grid, and the first coordinate beyond it.
    directed.push_back('{add_point(76799, 1000, 76799), 1'b0, '0});
    directed.push_back('{add_point(76800, 1000, 0), 1'b0, '0});
    directed.push_back('{add_point(0, 1000, COORD_MAX), 1'b0, '0});
    directed.push_back('{add_point(0, COORD_MIN, 0), 1'b0, '0});
    // Fractions on both sides of zero truncate to zero.
    directed.push_back('{add_point(-255, 1000, 255), 1'b0, '0});
    directed.push_back('{read_cell(CENTER_BIN, CENTER_BIN), 1'b0, '0});
    directed.push_back('{read_cell(0, 0), 1'b0, '0});
    directed.push_back('{read_cell(119, 119), 1'b0, '0});
    directed.push_back('{read_cell(0, CENTER_BIN), 1'b0, '0});
    directed.push_back('{read_cell(127, 127), 1'b1, '{MARK_EMPTY, 8'd0}});

    // Reset is held first; the block then clears its grid and keeps full
    // high until that pass is done, so the first request waits.
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      offer(directed[i].req, directed[i].typed, directed[i].typed_res, 1'b1);
    end
    run_random(40);

    // Lowest height threshold with occupancy at zero: almost every point
    // counts and any nonzero cell reads as occupied. One cell is then
    // hammered well past the top of its counter.
    set_thresholds(COORD_W'(COORD_MIN), 8'd0);
    run_random(20);
    repeat (260) begin
      offer(add_point(coord_in_bin(hot_row[5]), COORD_MAX, coord_in_bin(hot_col[5])),
            1'b0, '0, 1'b1);
    end
    offer(read_cell(hot_row[5], hot_col[5]), 1'b0, '0, 1'b1);

    // Highest thresholds: no point can count, no cell can be occupied.
    set_thresholds(COORD_W'(COORD_MAX), COUNT_MAX);
    run_random(20);

    // Back to the reset values. The result side then stalls for a long
    // stretch while reads keep coming, so the block fills and raises full.
    set_thresholds(HEIGHT_THR_RESET, OCC_THR_RESET);
    stall_results = 1'b1;
    for (int n = 0; n < 30; n++) begin
      offer(read_cell(hot_row[n % 6], hot_col[n % 6]), 1'b0, '0, 1'b0);
    end
    settle();

    set_thresholds(COORD_W'(int'($urandom_range(0, 6000)) - 3000),
                   COUNT_W'($urandom_range(0, 20)));
    run_random(30);

    // The tail runs without any idling on either side.
    set_thresholds(COORD_W'(int'($urandom_range(0, 3000)) - 1000),
                   COUNT_W'($urandom_range(0, 255)));
    steady_tail = 1'b1;
    run_random(30);

    push <= 1'b0;
    while (expected_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d requests (%0d reads) and %0d register writes over %0d settings.",
             requests, reads_sent, cfg_writes, settings + 1);
    $display("Compared %0d read results, including a saturated cell and a full stall.",
             results_seen);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
